### rtl/core/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

    localparam int unsigned DIGIT_BITS = 4;
    localparam int unsigned CHAR_BITS  = 6;

    localparam logic [DIGIT_BITS-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] BCD_ADJ       = 4'd3;
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO    = 6'd48;
    localparam logic [CHAR_BITS-1:0]  ASCII_NINE    = 6'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

endpackage

### rtl/core/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter: double dabble then digit-serial emission.
//
// Request channel: drive value and pulse start while busy is low; the request
// is taken at that clock edge and busy rises in the next cycle.
// Result channel: each decimal digit appears on digit_char as an ASCII code
// for exactly one cycle with strobe high, most significant digit first.
// Leading zeros are dropped; a zero value yields the single character '0'.
// last_digit is high with the least significant digit.
// Timing: the double dabble loop takes one input bit per cycle, then the BCD
// shift register offers one digit per cycle, NDIG = floor(VALUE_BITS *
// log10(2)) + 1 digits in all, suppressed ones included. busy stays high
// through conversion and emission, so a new request is not taken until the
// emission of the previous one is done. The final strobe is shown in the
// first cycle with busy low, so a new request may be taken in that same
// cycle.
// Reset returns the controller to idle and drops strobe; nothing else is
// kept between requests. The receiver has no way to stall the results and
// must take each one in the cycle it is shown.
module binary_to_decimal_ascii_top #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [VALUE_BITS-1:0]           value,
    output logic                            strobe,
    output logic [bda_pkg::CHAR_BITS-1:0]   digit_char,
    output logic                            last_digit
);
    import bda_pkg::*;

    localparam int unsigned NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int unsigned BCD_W  = NDIG * DIGIT_BITS;
    localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int unsigned DCNT_W = $clog2(NDIG + 1);

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCD_W-1:0]        bcd_adj;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DCNT_W-1:0]       dcnt_reg, dcnt_next;
    logic                    started_reg, started_next;
    logic                    strobe_reg, strobe_next;
    logic [CHAR_BITS-1:0]    char_reg, char_next;
    logic                    last_reg, last_next;

    logic [DIGIT_BITS-1:0]   top_digit;
    logic                    is_last;
    logic                    show;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_BITS];
    assign is_last   = (dcnt_reg == DCNT_W'(1));
    assign show      = (top_digit != '0) || started_reg || is_last;
    assign busy      = (state_reg != ST_IDLE);

    // Add three to every digit of five or more before the next shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] >= BCD_ADJ_LIMIT)
                bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
                    bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] + BCD_ADJ;
            else
                bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
                    bcd_reg[i*DIGIT_BITS +: DIGIT_BITS];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (is_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and result outputs.
    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        dcnt_next    = dcnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bin_next = value;
                    bcd_next = '0;
                    cnt_next = CNT_W'(VALUE_BITS);
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next     = bin_reg << 1;
                cnt_next     = cnt_reg - CNT_W'(1);
                dcnt_next    = DCNT_W'(NDIG);
                started_next = 1'b0;
            end
            ST_EMIT:
            begin
                strobe_next  = show;
                char_next    = ASCII_ZERO + {2'b00, top_digit};
                last_next    = is_last;
                started_next = show;
                bcd_next     = bcd_reg << DIGIT_BITS;
                dcnt_next    = dcnt_reg - DCNT_W'(1);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            strobe_reg  <= 1'b0;
            cnt_reg     <= '0;
            dcnt_reg    <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            cnt_reg     <= cnt_next;
            dcnt_reg    <= dcnt_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

`ifndef SYNTHESIS
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_digit |=> !strobe)
        else $error("strobe continued after the final digit");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE))
        else $error("digit_char outside '0'..'9'");

    a_take_request: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !strobe)
        else $error("request not taken");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_digit |-> busy)
        else $error("non-final digit shown while idle");
`endif

endmodule

### dv/binary_to_decimal_ascii_top_tb.sv
// Self-checking testbench for the binary to decimal ASCII converter.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_top_tb;

    import bda_pkg::*;

    localparam int unsigned VALUE_BITS  = 32;
    localparam int unsigned DEC_BASE    = 10;
    localparam int unsigned MAX_DIGITS  = 10;
    localparam int unsigned DRAIN_TAIL  = 60;
    localparam int unsigned MAX_GAP     = 60;
    localparam int unsigned PHASE_ITEMS = 100;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ascii;
        logic                 is_last;
    } digit_result_t;

    typedef struct {
        logic [VALUE_BITS-1:0] number;
        string                 text;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  busy;
    logic                  strobe;
    logic [CHAR_BITS-1:0]  digit_char;
    logic                  last_digit;

    digit_result_t expected_digits[$];
    int unsigned   values_sent;
    int unsigned   digits_checked;
    int unsigned   mismatch_count;
    int unsigned   ten_digit_values;

    // Rows with text carry the decimal string typed in; empty text goes to the predictor.
    directed_row_t directed_rows[] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{32'd99,         "99"},
        '{32'd100,        "100"},
        '{32'd999999999,  "999999999"},
        '{32'd1000000000, "1000000000"},
        '{32'hFFFFFFFF,   "4294967295"},
        '{32'hFFFFFFFE,   "4294967294"},
        '{32'h80000000,   "2147483648"},
        '{32'h7FFFFFFF,   "2147483647"},
        '{32'd1234567890, "1234567890"},
        '{32'd1000000001, ""},
        '{32'hAAAAAAAA,   ""},
        '{32'h55555555,   ""},
        '{32'h0000FFFF,   ""},
        '{32'hFFFF0000,   ""},
        '{32'd4000000000, ""},
        '{32'd10000,      ""},
        '{32'd0,          "0"},
        '{32'd7,          ""}
    };

    binary_to_decimal_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .digit_char(digit_char),
        .last_digit(last_digit)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("binary_to_decimal_ascii_top regression: fail");
        $finish;
    end

    // Split the number into decimal digits and queue them most significant first.
    function automatic void queue_decimal_digits(input logic [VALUE_BITS-1:0] number);
        logic [DIGIT_BITS-1:0] reversed [MAX_DIGITS];
        logic [VALUE_BITS-1:0] rest;
        digit_result_t         digit;
        int                    count;
        rest  = number;
        count = 0;
        do
        begin
            reversed[count] = DIGIT_BITS'(rest % DEC_BASE);
            rest            = rest / DEC_BASE;
            count++;
        end
        while (rest != 0);
        if (count == MAX_DIGITS)
            ten_digit_values++;
        for (int k = count - 1; k >= 0; k--)
        begin
            digit.ascii   = ASCII_ZERO + CHAR_BITS'(reversed[k]);
            digit.is_last = (k == 0);
            expected_digits.push_back(digit);
        end
    endfunction

    function automatic void queue_typed_digits(input string text);
        digit_result_t digit;
        for (int k = 0; k < text.len(); k++)
        begin
            digit.ascii   = ASCII_ZERO + CHAR_BITS'(text[k] - "0");
            digit.is_last = (k == text.len() - 1);
            expected_digits.push_back(digit);
        end
    endfunction

    // Mostly pick a digit count first so short runs are as common as long ones.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [63:0] lower;
        logic [63:0] upper;
        int unsigned ndigits;
        if ($urandom_range(9) < 3)
            return $urandom();
        ndigits = $urandom_range(1, MAX_DIGITS);
        lower   = 64'd1;
        for (int k = 1; k < ndigits; k++)
            lower = lower * DEC_BASE;
        upper = lower * DEC_BASE - 1;
        if (ndigits == 1)
            lower = 64'd0;
        if (upper > 64'hFFFFFFFF)
            upper = 64'hFFFFFFFF;
        return $urandom_range(32'(upper), 32'(lower));
    endfunction

    // Hold start high until the request is taken; leave it high for a back-to-back request.
    task automatic send_request(input logic [VALUE_BITS-1:0] number, input string text);
        value <= number;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        values_sent++;
        if (text.len() != 0)
            queue_typed_digits(text);
        else
            queue_decimal_digits(number);
    endtask

    task automatic sender_gap(input int unsigned idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
    endtask

    task automatic wait_for_all_digits();
        start <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned idle_pct [3] = '{38, 78, 0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].number, directed_rows[i].text);
            sender_gap(30);
        end
        wait_for_all_digits();
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(pick_value(), "");
                sender_gap(idle_pct[phase]);
            end
            wait_for_all_digits();
            @(posedge clk);
        end

        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Converted %0d values (%0d with ten digits) and checked %0d digit characters.",
                 values_sent, ten_digit_values, digits_checked);
        $display("Sender gaps of 38, 78 and 0 percent; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0)
            $display("binary_to_decimal_ascii_top regression: pass");
        else
            $display("binary_to_decimal_ascii_top regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin : check_digits
        digit_result_t want;
        if (rst_n && strobe)
        begin
            if (expected_digits.size() == 0)
            begin
                $error("digit_char: expected none, got %0d (last_digit %0d)",
                       digit_char, last_digit);
                mismatch_count++;
            end
            else
            begin
                want = expected_digits.pop_front();
                digits_checked++;
                if (digit_char !== want.ascii)
                begin
                    $error("digit_char: expected %0d, got %0d", want.ascii, digit_char);
                    mismatch_count++;
                end
                if (last_digit !== want.is_last)
                begin
                    $error("last_digit: expected %0d, got %0d", want.is_last, last_digit);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
